>>> rtl/core/tcswb_pkg.sv
// shared constants, types and helper functions for the weighted cell-state error block
package tcswb_pkg;

    // counter and field widths
    localparam int COUNT_WIDTH     = 32;
    localparam int CELLS_PER_GROUP = 8;
    localparam int NUM_CODES       = 8;
    localparam int CODE_W          = $clog2(NUM_CODES);
    localparam int WEIGHT_W        = 8;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = WEIGHT_W;
    localparam int PAGE_W          = CELLS_PER_GROUP;
    localparam int GROUP_CNT_W     = $clog2(CELLS_PER_GROUP + 1);
    localparam int SUM_W           = 40;
    localparam int AVG_W           = 15;
    localparam int OUT_CNT_W       = 32;
    localparam int PROD_W          = COUNT_WIDTH + WEIGHT_W;
    localparam int ACC_W           = (PROD_W + 1 > SUM_W + 1) ? PROD_W + 1 : SUM_W + 1;
    // sum times 100 fits in seven more bits
    localparam int DVD_W           = SUM_W + 7;
    localparam int DIV_CNT_W       = $clog2(DVD_W);
    localparam int AVG_MAX         = 25500;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // weight register reset values, in tenths
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_CODES] =
        '{8'd30, 8'd4, 8'd52, 8'd3, 8'd20, 8'd22, 8'd80, 8'd5};

    // high-error codes
    localparam logic [CODE_W-1:0] CODE_HIGH_ERR_A = CODE_W'(2);
    localparam logic [CODE_W-1:0] CODE_HIGH_ERR_B = CODE_W'(6);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [GROUP_CNT_W-1:0] group_cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } tcswb_state_t;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        count_t           divisor;
    } tcswb_div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } tcswb_div_rsp_t;

    // control outputs of the sequencer
    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic acc_en;
        logic div_start;
        logic load_result;
    } tcswb_ctl_t;

    // saturating add of a small group count
    function automatic count_t sat_inc(count_t a, group_cnt_t b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH + 1)'(b);
        return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    // clamp a counter to the output field width
    function automatic logic [OUT_CNT_W-1:0] sat_out(count_t c);
        logic [63:0] ext;
        ext = 64'(c);
        return (ext > 64'(33'h0_FFFF_FFFF)) ? '1 : ext[OUT_CNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/tcswb_if.sv
// valid/ready channel interfaces for page-group input beats and result beats
interface tcswb_in_if;
    import tcswb_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] lsb_byte;
    logic [PAGE_W-1:0] csb_byte;
    logic [PAGE_W-1:0] msb_byte;
    logic              last;

    modport source (output valid, lsb_byte, csb_byte, msb_byte, last, input ready);
    modport sink   (input valid, lsb_byte, csb_byte, msb_byte, last, output ready);
endinterface

interface tcswb_out_if;
    import tcswb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SUM_W-1:0]     weighted_sum_tenths;
    logic [AVG_W-1:0]     average_milli;
    logic [OUT_CNT_W-1:0] total_cells;
    logic [OUT_CNT_W-1:0] high_error_cells;

    modport source (output valid, weighted_sum_tenths, average_milli, total_cells,
                    high_error_cells, input ready);
    modport sink   (input valid, weighted_sum_tenths, average_milli, total_cells,
                    high_error_cells, output ready);
endinterface

>>> rtl/core/tcswb_div.sv
// restoring divider, one quotient bit per cycle
module tcswb_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcswb_pkg::tcswb_div_req_t req,
    output tcswb_pkg::tcswb_div_rsp_t rsp
);
    import tcswb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    count_t               rem_reg, rem_next;
    count_t               divisor_reg, divisor_next;
    logic [DVD_W-1:0]     dq_reg, dq_next;

    logic [COUNT_WIDTH:0] rem_shift;
    logic                 fits;

    // trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[DVD_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
    end

    // next values
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        dq_next      = dq_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            divisor_next = req.divisor;
            dq_next      = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_WIDTH'(rem_shift - {1'b0, divisor_reg})
                            : rem_shift[COUNT_WIDTH-1:0];
            dq_next  = {dq_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        dq_reg      <= dq_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

>>> rtl/core/tlc_cell_state_weighted_ber_top.sv
// top level: per-code cell counting, weighted score and average for a triple-level flash stream
//
// Page-group beats without last are counted as they are accepted, so they can arrive back to back.
// A beat with last is counted and then starts the report: one shared 32x8 multiplier and
// accumulator walk the eight codes with a multiply and an accumulate state per code, a scale
// state multiplies the sum by 100, and a restoring divider produces the average at one quotient
// bit per cycle; if no cells were counted, the divider is skipped and the average is zero.
// The done state loads the result once the output register is free; until the block is back
// in idle it takes no beats. The result sits in an output register; while it waits, new beats
// are counted, and a following report waits only for that register to drain. Counters clear
// when a result is loaded. Configuration writes to indexes above 7 are ignored.
module tlc_cell_state_weighted_ber_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tcswb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcswb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    tcswb_in_if.sink                               items,
    tcswb_out_if.source                            results
);
    import tcswb_pkg::*;

    tcswb_state_t         state_reg, state_next;
    tcswb_ctl_t           ctl;

    logic [WEIGHT_W-1:0]  weight_reg [NUM_CODES];
    count_t               code_count_reg [NUM_CODES];
    count_t               code_count_next [NUM_CODES];
    count_t               cell_total_reg, cell_total_next;
    count_t               high_err_reg, high_err_next;
    logic [CODE_W-1:0]    idx_reg, idx_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     out_sum_reg, out_sum_next;
    logic [AVG_W-1:0]     out_avg_reg, out_avg_next;
    logic [OUT_CNT_W-1:0] out_total_reg, out_total_next;
    logic [OUT_CNT_W-1:0] out_high_reg, out_high_next;

    group_cnt_t           per_code [NUM_CODES];
    group_cnt_t           high_in_group;
    logic [CODE_W-1:0]    cell_code [CELLS_PER_GROUP];
    logic                 in_beat;
    logic                 out_free;
    logic                 idx_last;
    logic                 total_zero;
    logic [ACC_W-1:0]     acc_sum;
    logic [DVD_W-1:0]     sum_ext;
    logic [AVG_W-1:0]     avg_val;

    tcswb_div_req_t       div_req;
    tcswb_div_rsp_t       div_rsp;

    assign in_beat    = items.valid && ctl.in_ready;
    assign out_free   = !out_valid_reg || results.ready;
    assign idx_last   = idx_reg == CODE_W'(NUM_CODES - 1);
    assign total_zero = cell_total_reg == '0;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && items.last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = idx_last ? ST_SCALE : ST_MUL;
            end
            ST_SCALE:
            begin
                state_next = total_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:  ctl.in_ready    = 1'b1;
            ST_MUL:   ctl.mul_en      = 1'b1;
            ST_ACC:   ctl.acc_en      = 1'b1;
            ST_SCALE: ctl.div_start   = !total_zero;
            ST_DIV:   ctl = '0;
            ST_DONE:  ctl.load_result = out_free;
            default:  ctl = '0;
        endcase
    end

    // cell codes and per-code counts of the incoming group
    always_comb
    begin
        for (int j = 0; j < CELLS_PER_GROUP; j++)
        begin
            cell_code[j] = {items.msb_byte[j], items.csb_byte[j], items.lsb_byte[j]};
        end
        for (int c = 0; c < NUM_CODES; c++)
        begin
            per_code[c] = '0;
            for (int j = 0; j < CELLS_PER_GROUP; j++)
            begin
                per_code[c] = per_code[c] + group_cnt_t'(cell_code[j] == CODE_W'(c));
            end
        end
        high_in_group = per_code[CODE_HIGH_ERR_A] + per_code[CODE_HIGH_ERR_B];
    end

    // counters: count on a beat, clear when the result is loaded
    always_comb
    begin
        for (int c = 0; c < NUM_CODES; c++)
        begin
            code_count_next[c] = code_count_reg[c];
            if (ctl.load_result)
            begin
                code_count_next[c] = '0;
            end
            else if (in_beat)
            begin
                code_count_next[c] = sat_inc(code_count_reg[c], per_code[c]);
            end
        end
        cell_total_next = cell_total_reg;
        high_err_next   = high_err_reg;
        if (ctl.load_result)
        begin
            cell_total_next = '0;
            high_err_next   = '0;
        end
        else if (in_beat)
        begin
            cell_total_next = sat_inc(cell_total_reg, group_cnt_t'(CELLS_PER_GROUP));
            high_err_next   = sat_inc(high_err_reg, high_in_group);
        end
    end

    // shared multiply and saturating accumulate over the codes
    always_comb
    begin
        acc_sum   = ACC_W'(sum_reg) + ACC_W'(prod_reg);
        idx_next  = idx_reg;
        prod_next = prod_reg;
        sum_next  = sum_reg;
        if (in_beat)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        if (ctl.mul_en)
        begin
            prod_next = PROD_W'(code_count_reg[idx_reg]) * PROD_W'(weight_reg[idx_reg]);
        end
        if (ctl.acc_en)
        begin
            sum_next = (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
            idx_next = idx_reg + 1'b1;
        end
    end

    // sum times 100 as shifts and adds
    assign sum_ext = DVD_W'(sum_reg);

    always_comb
    begin
        div_req.start    = ctl.div_start;
        div_req.dividend = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);
        div_req.divisor  = cell_total_reg;
    end

    tcswb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // average with clamp, zero when no cells
    always_comb
    begin
        if (total_zero)
        begin
            avg_val = '0;
        end
        else if (div_rsp.quotient > DVD_W'(AVG_MAX))
        begin
            avg_val = AVG_W'(AVG_MAX);
        end
        else
        begin
            avg_val = div_rsp.quotient[AVG_W-1:0];
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_avg_next   = out_avg_reg;
        out_total_next = out_total_reg;
        out_high_next  = out_high_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.load_result)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = sum_reg;
            out_avg_next   = avg_val;
            out_total_next = sat_out(cell_total_reg);
            out_high_next  = sat_out(high_err_reg);
        end
    end

    // control state, counters and weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            cell_total_reg <= '0;
            high_err_reg   <= '0;
            for (int c = 0; c < NUM_CODES; c++)
            begin
                code_count_reg[c] <= '0;
                weight_reg[c]     <= WEIGHT_RESET[c];
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            cell_total_reg <= cell_total_next;
            high_err_reg   <= high_err_next;
            for (int c = 0; c < NUM_CODES; c++)
            begin
                code_count_reg[c] <= code_count_next[c];
            end
            if (cfg_we && (cfg_index < CFG_INDEX_W'(NUM_CODES)))
            begin
                weight_reg[cfg_index[CODE_W-1:0]] <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        out_sum_reg   <= out_sum_next;
        out_avg_reg   <= out_avg_next;
        out_total_reg <= out_total_next;
        out_high_reg  <= out_high_next;
    end

    assign items.ready                 = ctl.in_ready;
    assign results.valid               = out_valid_reg;
    assign results.weighted_sum_tenths = out_sum_reg;
    assign results.average_milli       = out_avg_reg;
    assign results.total_cells         = out_total_reg;
    assign results.high_error_cells    = out_high_reg;

endmodule
